// ===== hw/rtl/fix_message_validator_assert.svh =====
// Assertion macros for the validator's checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FIX_MESSAGE_VALIDATOR_ASSERT_SVH
`define FIX_MESSAGE_VALIDATOR_ASSERT_SVH

// Same-cycle implication.
`define FMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fix_message_validator: check failed");

// Next-cycle implication.
`define FMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fix_message_validator: check failed");

`endif

// ===== hw/rtl/fmv_pkg.sv =====
// Types and constants for the FIX message validator.
// No dependencies; used by every module of the block.
package fmv_pkg;

  localparam int unsigned LenBits = 20;
  localparam int unsigned TagBits = 20;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EQ_BYTE  = 8'h3d;
  localparam logic [7:0] ZERO_CH  = 8'h30;
  localparam logic [7:0] NINE_CH  = 8'h39;

  localparam int unsigned TAG_BEGIN   = 8;
  localparam int unsigned TAG_BODYLEN = 9;
  localparam int unsigned TAG_CHKSUM  = 10;
  localparam int unsigned TAG_SEQNUM  = 34;
  localparam int unsigned TAG_MSGTYPE = 35;
  localparam int unsigned TAG_SENDER  = 49;
  localparam int unsigned TAG_SENDTM  = 52;
  localparam int unsigned TAG_TARGET  = 56;

  localparam int unsigned NumRequired = 5;
  localparam int unsigned ChkMax      = 255;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_BODYLEN  = 3'd2,
    ERR_MALFORM  = 3'd3,
    ERR_DUP      = 3'd4,
    ERR_CHECKSUM = 3'd5,
    ERR_MISSING  = 3'd6
  } err_e;

  typedef enum logic [4:0] {
    PH_H8    = 5'b00001,
    PH_H9    = 5'b00010,
    PH_BODY  = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [TagBits-1:0] field_tag;
    logic [7:0]         value_byte;
    logic               value_valid;
    logic               field_end;
    logic               msg_done;
    logic               msg_ok;
    err_e               error_code;
  } out_item_t;

endpackage

// ===== hw/rtl/fmv_parser.sv =====
// Per-byte parse state and next-state logic of the FIX message validator.
// Depends on fmv_pkg. State advances only on en_i; result_o is combinational.
module fmv_parser import fmv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  phase_e             phase_q, phase_d;
  logic [TagBits-1:0] tag_q, tag_d;
  logic               has_digit_q, has_digit_d;
  logic               in_value_q, in_value_d;
  logic [LenBits-1:0] num_q, num_d;
  logic [LenBits-1:0] remain_q, remain_d;
  logic [7:0]         sum_q, sum_d;
  logic [NumRequired-1:0] seen_q, seen_d;
  logic               bad_q, bad_d;
  err_e               pend_q, pend_d;

  logic [7:0]         b;
  logic               digit;
  logic [3:0]         d;
  logic [TagBits+3:0] tag_n;
  logic               tag_ovf;
  logic [TagBits-1:0] tag_sat;
  logic [LenBits+3:0] num_n;
  logic               len_ovf;
  logic [LenBits-1:0] len_sat;
  logic               chk_ovf;
  logic [LenBits-1:0] chk_sat;
  logic               tag_ok;
  logic [NumRequired-1:0] req_bit;
  logic [TagBits-1:0] hdr_tag;

  function automatic logic [NumRequired-1:0] required_bit(logic [TagBits-1:0] tag);
    logic [NumRequired-1:0] r;
    r = '0;
    if (tag == TagBits'(TAG_SEQNUM))       r = NumRequired'(1);
    else if (tag == TagBits'(TAG_MSGTYPE)) r = NumRequired'(2);
    else if (tag == TagBits'(TAG_SENDER))  r = NumRequired'(4);
    else if (tag == TagBits'(TAG_SENDTM))  r = NumRequired'(8);
    else if (tag == TagBits'(TAG_TARGET))  r = NumRequired'(16);
    return r;
  endfunction

  assign b     = item_i.data_byte;
  assign digit = b inside {[ZERO_CH:NINE_CH]};
  assign d     = digit ? 4'(b - ZERO_CH) : 4'd0;

  // acc * 10 + d, saturating at the field maximum
  assign tag_n   = ({tag_q, 3'b000} + {2'b00, tag_q, 1'b0}) + (TagBits+4)'(d);
  assign tag_ovf = |tag_n[TagBits+3:TagBits];
  assign tag_sat = tag_ovf ? '1 : tag_n[TagBits-1:0];

  assign num_n   = ({num_q, 3'b000} + {2'b00, num_q, 1'b0}) + (LenBits+4)'(d);
  assign len_ovf = |num_n[LenBits+3:LenBits];
  assign len_sat = len_ovf ? '1 : num_n[LenBits-1:0];
  assign chk_ovf = |num_n[LenBits+3:8];
  assign chk_sat = chk_ovf ? LenBits'(ChkMax) : num_n[LenBits-1:0];

  assign tag_ok  = !bad_q && has_digit_q && (tag_q != '0);
  assign req_bit = required_bit(tag_q);
  assign hdr_tag = (phase_q == PH_H8) ? TagBits'(TAG_BEGIN) : TagBits'(TAG_BODYLEN);

  always_comb begin
    phase_d     = phase_q;
    tag_d       = tag_q;
    has_digit_d = has_digit_q;
    in_value_d  = in_value_q;
    num_d       = num_q;
    remain_d    = remain_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    bad_d       = bad_q;
    pend_d      = pend_q;
    result_o    = '0;

    case (phase_q)
      PH_H8, PH_H9: begin
        sum_d = sum_q + b;
        if (!in_value_q) begin
          if (digit) begin
            tag_d       = tag_sat;
            bad_d       = bad_q | tag_ovf;
            has_digit_d = 1'b1;
          end else if (b == EQ_BYTE && !bad_q && has_digit_q && tag_q == hdr_tag) begin
            in_value_d  = 1'b1;
            has_digit_d = 1'b0;
            num_d       = '0;
          end else begin
            result_o.msg_done   = 1'b1;
            result_o.error_code = ERR_HEADER;
            phase_d             = PH_DONE;
          end
        end else if (phase_q == PH_H8) begin
          if (b == SOH_BYTE) begin
            tag_d = '0; has_digit_d = 1'b0; in_value_d = 1'b0; num_d = '0; bad_d = 1'b0;
            phase_d = PH_H9;
          end
        end else if (digit) begin
          num_d       = len_sat;
          bad_d       = bad_q | len_ovf;
          has_digit_d = 1'b1;
        end else if (b == SOH_BYTE) begin
          if (bad_q || !has_digit_q || num_q == '0) begin
            result_o.msg_done   = 1'b1;
            result_o.error_code = ERR_BODYLEN;
            phase_d             = PH_DONE;
          end else begin
            remain_d = num_q;
            tag_d = '0; has_digit_d = 1'b0; in_value_d = 1'b0; num_d = '0; bad_d = 1'b0;
            pend_d  = ERR_NONE;
            phase_d = PH_BODY;
          end
        end else begin
          bad_d = 1'b1;
        end
      end

      PH_BODY: begin
        sum_d    = sum_q + b;
        remain_d = remain_q - 1'b1;
        if (pend_q == ERR_NONE) begin
          if (!in_value_q) begin
            if (digit) begin
              tag_d       = tag_sat;
              bad_d       = bad_q | tag_ovf;
              has_digit_d = 1'b1;
            end else if (b == EQ_BYTE) begin
              in_value_d = 1'b1;
            end else if (b == SOH_BYTE) begin
              pend_d = ERR_MALFORM;
            end else begin
              bad_d = 1'b1;
            end
          end else if (b == SOH_BYTE) begin
            if (!tag_ok) begin
              pend_d = ERR_MALFORM;
            end else if ((seen_q & req_bit) != '0) begin
              pend_d = ERR_DUP;
            end else begin
              seen_d             = seen_q | req_bit;
              result_o.field_end = 1'b1;
            end
            tag_d = '0; has_digit_d = 1'b0; in_value_d = 1'b0; num_d = '0; bad_d = 1'b0;
          end else if (tag_ok) begin
            result_o.field_tag   = tag_q;
            result_o.value_byte  = b;
            result_o.value_valid = 1'b1;
          end
        end
        // body length used up with this byte
        if (remain_q == LenBits'(1)) begin
          if (pend_d != ERR_NONE) begin
            result_o.msg_done   = 1'b1;
            result_o.error_code = pend_d;
            phase_d             = PH_DONE;
          end else begin
            tag_d = '0; has_digit_d = 1'b0; in_value_d = 1'b0; num_d = '0; bad_d = 1'b0;
            phase_d = PH_TRAIL;
          end
        end
      end

      PH_TRAIL: begin
        if (!in_value_q) begin
          if (digit) begin
            tag_d       = tag_sat;
            bad_d       = bad_q | tag_ovf;
            has_digit_d = 1'b1;
          end else if (b == EQ_BYTE && !bad_q && has_digit_q &&
                       tag_q == TagBits'(TAG_CHKSUM)) begin
            in_value_d  = 1'b1;
            has_digit_d = 1'b0;
            num_d       = '0;
          end else begin
            result_o.msg_done   = 1'b1;
            result_o.error_code = ERR_BODYLEN;
            phase_d             = PH_DONE;
          end
        end else if (digit) begin
          num_d       = chk_sat;
          bad_d       = bad_q | chk_ovf;
          has_digit_d = 1'b1;
        end else if (b == SOH_BYTE) begin
          result_o.msg_done = 1'b1;
          phase_d           = PH_DONE;
          if (bad_q || !has_digit_q || num_q != LenBits'(sum_q)) begin
            result_o.error_code = ERR_CHECKSUM;
          end else if (seen_q != '1) begin
            result_o.error_code = ERR_MISSING;
          end else begin
            result_o.msg_ok = 1'b1;
          end
        end else begin
          bad_d = 1'b1;
        end
      end

      default: begin
      end
    endcase

    // end of buffer: fail an open message, then start over
    if (item_i.last_byte) begin
      if (phase_d != PH_DONE) begin
        result_o.msg_done   = 1'b1;
        result_o.msg_ok     = 1'b0;
        result_o.error_code = (phase_d inside {PH_H8, PH_H9}) ? ERR_HEADER : ERR_BODYLEN;
      end
      phase_d     = PH_H8;
      tag_d       = '0;
      has_digit_d = 1'b0;
      in_value_d  = 1'b0;
      num_d       = '0;
      bad_d       = 1'b0;
      remain_d    = '0;
      sum_d       = '0;
      seen_d      = '0;
      pend_d      = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_H8;
      tag_q       <= '0;
      has_digit_q <= 1'b0;
      in_value_q  <= 1'b0;
      num_q       <= '0;
      remain_q    <= '0;
      sum_q       <= '0;
      seen_q      <= '0;
      bad_q       <= 1'b0;
      pend_q      <= ERR_NONE;
    end else if (en_i) begin
      phase_q     <= phase_d;
      tag_q       <= tag_d;
      has_digit_q <= has_digit_d;
      in_value_q  <= in_value_d;
      num_q       <= num_d;
      remain_q    <= remain_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      bad_q       <= bad_d;
      pend_q      <= pend_d;
    end
  end

endmodule

// ===== hw/rtl/fix_message_validator.sv =====
// FIX tag=value message validator, top level.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one raw byte
//   per request plus a last_byte flag marking the end of the raw buffer.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result per input byte, in order: body value bytes with their tag,
//   field-end marks, and the message verdict with an error code.
// Datapath: an accepted byte is parsed from the input register and its
//   result is registered into out_data_o.
// Throughput: one byte per cycle while out_ready_i is high; the parse state
//   updates once per byte, so consecutive bytes follow back to back.
// Reset: rst_ni (async, active low) empties both registers and returns the
//   parser to expecting header tag 8.
// Stall: while out_ready_i is low the result holds; the input register still
//   takes one more byte, then in_ready_o drops until the output drains.
// Depends on fmv_pkg and fmv_parser.
module fix_message_validator import fmv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  fmv_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/fmv_checker.sv =====
// Port-level checks for the FIX message validator, bound to the top level.
// Depends on fmv_pkg and fix_message_validator_assert.svh.
`include "fix_message_validator_assert.svh"

module fmv_checker import fmv_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  `FMV_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // an empty output register always leaves room for a request
  `FMV_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o)

  `FMV_ASSERT_IMP(a_verdict, out_valid_o && !out_data_o.msg_done, !out_data_o.msg_ok && out_data_o.error_code == ERR_NONE)

  `FMV_ASSERT_IMP(a_ok_clean, out_valid_o && out_data_o.msg_ok, out_data_o.error_code == ERR_NONE)

  `FMV_ASSERT_IMP(a_value_excl, out_valid_o && out_data_o.value_valid, !out_data_o.field_end)

endmodule

bind fix_message_validator fmv_checker u_fmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
